### rtl/afu_pkg.sv
package afu_pkg;

	localparam int FRAC_BITS = 12;
	localparam int WORK_BITS = 32;
	localparam int DIV_ST    = 11;
	localparam int DIV_STEPS = 3;
	localparam int QBITS     = DIV_ST * DIV_STEPS;

	typedef logic [WORK_BITS:0] wnum_t;
	typedef wnum_t exp_int_t [32];
	typedef wnum_t exp_seg_t [64];
	typedef wnum_t ln_tab_t [QBITS + 1];

	typedef enum logic [3:0] {
		KIND_NONE     = 4'd0,
		KIND_SIGMOID  = 4'd1,
		KIND_RELU     = 4'd2,
		KIND_TANH     = 4'd3,
		KIND_IDENT    = 4'd4,
		KIND_LEAKY    = 4'd5,
		KIND_SOFTPLUS = 4'd6,
		KIND_SOFTSIGN = 4'd7,
		KIND_SWISH    = 4'd8
	} act_kind_t;

	typedef enum logic [0:0] {
		REG_KIND  = 1'b0,
		REG_DERIV = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               neg;
		logic               der;
		logic [3:0]         kind;
		logic signed [15:0] x;
		logic [15:0]        a;
	} ctl_t;

	localparam wnum_t ONE_W = wnum_t'(1) << WORK_BITS;
	localparam logic [15:0] ONE_Y = 16'(1 << FRAC_BITS);
	localparam logic [15:0] LEAKY_D = 16'(((2 << FRAC_BITS) + 100) / 200);

	// Fixed point with 60 fraction bits, e^-f for 0 <= f <= 1.
	function automatic logic [127:0] exp_series(input logic [127:0] f);
		logic [127:0] term;
		logic [127:0] sum_p;
		logic [127:0] sum_n;
		term  = 128'(1) << 60;
		sum_p = term;
		sum_n = '0;
		for (int n = 1; n <= 40; n++) begin
			term = ((term * f) >> 60) / 128'(n);
			if (n[0]) sum_n = sum_n + term;
			else sum_p = sum_p + term;
		end
		return sum_p - sum_n;
	endfunction

	function automatic wnum_t to_w(input logic [127:0] v);
		logic [127:0] r;
		r = (v + (128'(1) << 27)) >> 28;
		return wnum_t'(r);
	endfunction

	function automatic exp_int_t build_exp_int();
		exp_int_t tab;
		logic [127:0] e1;
		logic [127:0] acc;
		e1  = exp_series(128'(1) << 60);
		acc = 128'(1) << 60;
		for (int n = 0; n < 32; n++) begin
			tab[n] = to_w(acc);
			acc = (acc * e1) >> 60;
		end
		return tab;
	endfunction

	function automatic exp_seg_t build_exp_seg(input int sh);
		exp_seg_t tab;
		for (int j = 0; j < 64; j++) begin
			tab[j] = to_w(exp_series(128'(j) << (60 - sh)));
		end
		return tab;
	endfunction

	function automatic ln_tab_t build_ln();
		ln_tab_t tab;
		logic [127:0] z;
		logic [127:0] pw;
		logic [127:0] sp;
		logic [127:0] sn;
		tab[0] = '0;
		for (int k = 1; k <= QBITS; k++) begin
			z  = 128'(1) << (60 - k);
			pw = z;
			sp = '0;
			sn = '0;
			for (int n = 1; n <= 64; n++) begin
				if (n[0]) sp = sp + pw / 128'(n);
				else sn = sn + pw / 128'(n);
				pw = (pw * z) >> 60;
			end
			tab[k] = to_w(sp - sn);
		end
		return tab;
	endfunction

	localparam exp_int_t EXP_INT = build_exp_int();
	localparam exp_seg_t EXP_MID = build_exp_seg(6);
	localparam exp_seg_t EXP_LO  = build_exp_seg(12);
	localparam ln_tab_t  LN_TAB  = build_ln();

endpackage

### rtl/afu_if.sv
interface afu_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_in;
	modport source(output valid, output x_in, input ready);
	modport sink(input valid, input x_in, output ready);
endinterface

interface afu_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] y_out;
	logic               clipped;
	modport source(output valid, output y_out, output clipped, input ready);
	modport sink(input valid, input y_out, input clipped, output ready);
endinterface

### rtl/activation_function_unit.sv
// Activation unit for Q4.12 samples: one request is taken per clock while the skid entry of
// the output register is empty. Each request passes the exponential table lookups and then
// the 11-stage division and logarithm pipeline (three quotient bits and three log steps per
// stage); a two-entry output register keeps input acceptance going while one finished
// result waits to be taken.
module activation_function_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [0:0] cfg_index,
	input  logic [3:0] cfg_data,
	afu_in_if.sink     in_ch,
	afu_out_if.source  out_ch
);
	import afu_pkg::*;

	logic [3:0] kind_q;
	logic       der_q;
	logic       en;

	logic  v_s1, v_s2, v_s3, v_s4;
	ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	wnum_t ei_s2, em_s2, el_s2, el_s3;
	logic [15:0] d_s2;
	wnum_t m1_s3, e_s4;
	logic [31:0] dsq_s3, dsq_s4;

	logic             div_v_s   [DIV_ST + 1];
	ctl_t             div_ctl_s [DIV_ST + 1];
	logic [64:0]      div_rem_s [DIV_ST + 1];
	logic [33:0]      div_den_s [DIV_ST + 1];
	logic [QBITS-1:0] div_quo_s [DIV_ST + 1];
	logic [33:0]      ln_y_s    [DIV_ST + 1];
	logic [33:0]      ln_t_s    [DIV_ST + 1];
	logic [32:0]      ln_s_s    [DIV_ST + 1];

	logic  v_s17, v_s18, v_s19, v_s20;
	ctl_t  ctl_s17, ctl_s18;
	wnum_t sg_s17, p_s17, tsq_s17, t_s17, ln_s17;
	wnum_t sg_s18, p_s18, tsq_s18, t_s18, ln_s18;
	logic [36:0] m_s17, m_s18, q2_s18;
	logic [15:0] qr_s17, qr_s18;
	logic signed [39:0] val_s19;
	logic signed [17:0] ys_s19;
	logic               tr_s19;
	logic signed [15:0] y_s20;
	logic               clip_s20;

	logic               out_v_q, skid_v_q;
	logic signed [15:0] out_y_q, skid_y_q;
	logic               out_c_q, skid_c_q;

	assign en = !skid_v_q;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			der_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KIND:  kind_q <= cfg_data;
				REG_DERIV: der_q  <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic [16:0] b_arg;
	assign b_arg = (ctl_s1.kind == KIND_TANH) ? {ctl_s1.a, 1'b0} : {1'b0, ctl_s1.a};

	logic [65:0] prod1, prod2;
	assign prod1 = 66'(ei_s2) * 66'(em_s2);
	assign prod2 = 66'(m1_s3) * 66'(el_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.neg  <= in_ch.x_in[15];
			ctl_s1.der  <= der_q;
			ctl_s1.kind <= kind_q;
			ctl_s1.x    <= in_ch.x_in;
			ctl_s1.a    <= in_ch.x_in[15] ? 16'(-in_ch.x_in) : 16'(in_ch.x_in);
			ctl_s2 <= ctl_s1;
			ei_s2  <= EXP_INT[b_arg[16:12]];
			em_s2  <= EXP_MID[b_arg[11:6]];
			el_s2  <= EXP_LO[b_arg[5:0]];
			d_s2   <= ONE_Y + ctl_s1.a;
			ctl_s3 <= ctl_s2;
			m1_s3  <= prod1[64:32];
			el_s3  <= el_s2;
			dsq_s3 <= 32'(d_s2) * 32'(d_s2);
			ctl_s4 <= ctl_s3;
			e_s4   <= prod2[64:32];
			dsq_s4 <= dsq_s3;
		end
	end

	logic [64:0] num_c;
	logic [33:0] den_c;
	always_comb begin
		unique case (ctl_s4.kind)
			KIND_SIGMOID, KIND_TANH, KIND_SOFTPLUS, KIND_SWISH: begin
				num_c = 65'(1) << 64;
				den_c = 34'(ONE_W) + 34'(e_s4);
			end
			KIND_SOFTSIGN: begin
				num_c = ctl_s4.der ? (65'(1) << (3 * FRAC_BITS)) : (65'(ctl_s4.a) << FRAC_BITS);
				den_c = ctl_s4.der ? 34'(dsq_s4) : 34'(ONE_Y) + 34'(ctl_s4.a);
			end
			KIND_LEAKY: begin
				num_c = 65'(ctl_s4.a);
				den_c = 34'd100;
			end
			default: begin
				num_c = '0;
				den_c = 34'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (en) div_v_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_ctl_s[0] <= ctl_s4;
			div_rem_s[0] <= num_c;
			div_den_s[0] <= den_c;
			div_quo_s[0] <= '0;
			ln_y_s[0]    <= 34'(ONE_W) + 34'(e_s4);
			ln_t_s[0]    <= 34'(ONE_W);
			ln_s_s[0]    <= '0;
		end
	end

	for (genvar j = 0; j < DIV_ST; j++) begin : g_div
		logic [64:0]      r_c;
		logic [QBITS-1:0] q_c;
		logic [33:0]      t_c;
		logic [32:0]      s_c;

		always_comb begin
			r_c = div_rem_s[j];
			q_c = div_quo_s[j];
			t_c = ln_t_s[j];
			s_c = ln_s_s[j];
			for (int t = 0; t < DIV_STEPS; t++) begin
				if (67'(r_c) >= (67'(div_den_s[j]) << (QBITS - 1 - (j * DIV_STEPS + t)))) begin
					r_c = 65'(67'(r_c) - (67'(div_den_s[j]) << (QBITS - 1 - (j * DIV_STEPS + t))));
					q_c[QBITS - 1 - (j * DIV_STEPS + t)] = 1'b1;
				end
				if ((t_c + (t_c >> (j * DIV_STEPS + t + 1))) <= ln_y_s[j]) begin
					t_c = t_c + (t_c >> (j * DIV_STEPS + t + 1));
					s_c = s_c + LN_TAB[j * DIV_STEPS + t + 1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[j + 1] <= 1'b0;
			else if (en) div_v_s[j + 1] <= div_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_ctl_s[j + 1] <= div_ctl_s[j];
				div_rem_s[j + 1] <= r_c;
				div_den_s[j + 1] <= div_den_s[j];
				div_quo_s[j + 1] <= q_c;
				ln_y_s[j + 1]    <= ln_y_s[j];
				ln_t_s[j + 1]    <= t_c;
				ln_s_s[j + 1]    <= s_c;
			end
		end
	end

	wnum_t       sp_c, om_c, sg_c, t_c;
	logic [65:0] pp_c, tt_c;
	logic [48:0] mm_c, q2_c;
	logic [33:0] rr_c;
	logic        up_c;
	ctl_t        ctl_d;
	assign ctl_d = div_ctl_s[DIV_ST];
	assign sp_c = (div_quo_s[DIV_ST] > ONE_W) ? ONE_W : wnum_t'(div_quo_s[DIV_ST]);
	assign om_c = ONE_W - sp_c;
	assign sg_c = ctl_d.neg ? om_c : sp_c;
	assign pp_c = 66'(sp_c) * 66'(om_c);
	assign t_c  = wnum_t'({1'b0, sp_c, 1'b0} - 35'(ONE_W));
	assign tt_c = 66'(t_c) * 66'(t_c);
	assign mm_c = 49'(ctl_d.a) * 49'(sg_c);
	assign rr_c = div_rem_s[DIV_ST][33:0];
	assign up_c = rr_c >= (div_den_s[DIV_ST] - rr_c);
	assign q2_c = 49'(ctl_s17.a) * 49'(p_s17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
		end else if (en) begin
			v_s17 <= div_v_s[DIV_ST];
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
		end
	end

	logic signed [39:0] val_c;
	logic signed [17:0] ys_c;
	logic               tr_c;
	logic signed [17:0] qr_sv;
	assign qr_sv = $signed({2'b00, qr_s18});

	always_comb begin
		tr_c  = 1'b1;
		val_c = '0;
		unique case (ctl_s18.kind)
			KIND_SIGMOID:
				val_c = ctl_s18.der ? $signed(40'(p_s18)) : $signed(40'(sg_s18));
			KIND_TANH: begin
				if (ctl_s18.der) val_c = $signed(40'(ONE_W - tsq_s18));
				else if (ctl_s18.neg) val_c = -$signed(40'(t_s18));
				else val_c = $signed(40'(t_s18));
			end
			KIND_SOFTPLUS: begin
				if (ctl_s18.der) val_c = $signed(40'(sg_s18));
				else if (ctl_s18.neg) val_c = $signed(40'(ln_s18));
				else val_c = $signed(40'(ln_s18) + (40'(ctl_s18.a) << (WORK_BITS - FRAC_BITS)));
			end
			KIND_SWISH: begin
				if (ctl_s18.der && ctl_s18.neg)
					val_c = $signed(40'(sg_s18)) - $signed(40'(q2_s18));
				else if (ctl_s18.der) val_c = $signed(40'(sg_s18)) + $signed(40'(q2_s18));
				else if (ctl_s18.neg) val_c = -$signed(40'(m_s18));
				else val_c = $signed(40'(m_s18));
			end
			default: tr_c = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctl_s18.kind)
			KIND_RELU: begin
				if (ctl_s18.neg) ys_c = '0;
				else ys_c = ctl_s18.der ? $signed({2'b00, ONE_Y}) : 18'(ctl_s18.x);
			end
			KIND_IDENT:
				ys_c = ctl_s18.der ? $signed({2'b00, ONE_Y}) : 18'(ctl_s18.x);
			KIND_LEAKY: begin
				if (!ctl_s18.neg) ys_c = ctl_s18.der ? $signed({2'b00, ONE_Y}) : 18'(ctl_s18.x);
				else ys_c = ctl_s18.der ? $signed({2'b00, LEAKY_D}) : -qr_sv;
			end
			KIND_SOFTSIGN: begin
				if (ctl_s18.der || !ctl_s18.neg) ys_c = qr_sv;
				else ys_c = -qr_sv;
			end
			default: ys_c = 18'(ctl_s18.x);
		endcase
	end

	logic [39:0]        mag_c;
	logic [20:0]        rnd_c;
	logic signed [21:0] yr_c, yy_c;
	assign mag_c = val_s19[39] ? 40'(-val_s19) : 40'(val_s19);
	assign rnd_c = 21'((mag_c + 40'(1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS));
	assign yr_c  = val_s19[39] ? -$signed({1'b0, rnd_c}) : $signed({1'b0, rnd_c});
	assign yy_c  = tr_s19 ? yr_c : 22'(ys_s19);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s17 <= ctl_d;
			sg_s17  <= sg_c;
			p_s17   <= pp_c[64:32];
			tsq_s17 <= tt_c[64:32];
			t_s17   <= t_c;
			ln_s17  <= ln_s_s[DIV_ST];
			m_s17   <= mm_c[48:12];
			qr_s17  <= 16'(div_quo_s[DIV_ST]) + 16'(up_c);
			ctl_s18 <= ctl_s17;
			sg_s18  <= sg_s17;
			p_s18   <= p_s17;
			tsq_s18 <= tsq_s17;
			t_s18   <= t_s17;
			ln_s18  <= ln_s17;
			m_s18   <= m_s17;
			q2_s18  <= q2_c[48:12];
			qr_s18  <= qr_s17;
			val_s19 <= val_c;
			ys_s19  <= ys_c;
			tr_s19  <= tr_c;
			if (yy_c > 22'sd32767) begin
				y_s20    <= 16'sh7FFF;
				clip_s20 <= 1'b1;
			end else if (yy_c < -22'sd32768) begin
				y_s20    <= 16'sh8000;
				clip_s20 <= 1'b1;
			end else begin
				y_s20    <= 16'(yy_c);
				clip_s20 <= 1'b0;
			end
		end
	end

	logic push;
	assign push = en && v_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ch.ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ch.ready) begin
			out_y_q <= skid_v_q ? skid_y_q : y_s20;
			out_c_q <= skid_v_q ? skid_c_q : clip_s20;
		end else if (push) begin
			skid_y_q <= y_s20;
			skid_c_q <= clip_s20;
		end
	end

	assign out_ch.valid   = out_v_q;
	assign out_ch.y_out   = out_y_q;
	assign out_ch.clipped = out_c_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ch.ready))
		else $error("skid entry filled while the output was free");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_c_q) |-> (out_y_q == 16'sh7FFF || out_y_q == 16'sh8000))
		else $error("clipped result is not a range limit");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> (out_v_q && (skid_v_q || !$past(out_ch.ready) || out_v_q)))
		else $error("output queue lost an entry");

endmodule
